// ===== design/wrapped_csv_field_splitter_core_assert.svh =====
// Assertion macros for the wrapped CSV field splitter.
// Used by the top level; needs nothing else.
`ifndef WRAPPED_CSV_FIELD_SPLITTER_CORE_ASSERT_SVH
`define WRAPPED_CSV_FIELD_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CSVS_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("splitter check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CSVS_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("splitter check failed");

`endif

// ===== design/csvs_pkg.sv =====
// Shared types and constants of the wrapped CSV field splitter.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package csvs_pkg;

  // Marker length and the number of window bytes left at a line end.
  localparam int WinLen   = 7;
  localparam int FlushLen = WinLen - 1;

  // Command queue between the front and the back.
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] MaxFieldsReset = 8'd30;
  localparam logic [7:0] CommaChar      = 8'h2c;

  // Wrapper head and tail markers, oldest byte first.
  localparam logic [7:0] HeadMark [WinLen] =
    '{8'h23, 8'h44, 8'h4f, 8'h47, 8'h45, 8'h53, 8'h40};
  localparam logic [7:0] TailMark [WinLen] =
    '{8'h40, 8'h44, 8'h4f, 8'h47, 8'h45, 8'h45, 8'h23};

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CONTENT = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  // One queue entry: either a single ready result or a line-end flush job.
  typedef struct packed {
    logic                      flush;
    kind_t                     kind;
    logic [7:0]                data;
    logic [7:0]                idx;
    logic [FlushLen-1:0][7:0]  win;
    logic [2:0]                count;
    logic                      in_wrap;
    logic                      has_bytes;
  } csvs_cmd_t;

endpackage

`default_nettype wire

// ===== design/csvs_fifo.sv =====
// Short command queue between the splitter front and back.
// Depends on csvs_pkg for the entry type and depth.
`default_nettype none

module csvs_fifo
  import csvs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  csvs_cmd_t      din,
  output logic           full,
  input  wire logic      pop,
  output csvs_cmd_t      dout,
  output logic           empty
);

  csvs_cmd_t            mem [FifoDepth];
  logic [FifoAw-1:0]    wr_ptr;
  logic [FifoAw-1:0]    rd_ptr;
  logic [FifoAw:0]      cnt;

  assign full  = (cnt == (FifoAw + 1)'(FifoDepth));
  assign empty = (cnt == '0);
  assign dout  = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/csvs_front.sv =====
// Front of the splitter: accepts input bytes, runs the marker window and
// field bookkeeping, and queues results or line-end flush jobs. Uses csvs_pkg.
`default_nettype none

module csvs_front
  import csvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  input  wire logic [7:0]  max_fields,
  input  wire logic        q_full,
  output logic             q_push,
  output csvs_cmd_t        q_cmd
);

  logic [7:0] win      [WinLen];
  logic [7:0] win_next [WinLen];
  logic [7:0] win_ext  [WinLen];
  logic [2:0] count, count_next;
  logic       in_wrap, in_wrap_next;
  logic       skip, skip_next;
  logic [7:0] fd, fd_next;
  logic       has, has_next;
  logic       accept;
  logic       is_head;
  logic       is_tail;
  logic [7:0] oldest;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Window with the incoming byte placed after the held ones.
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      win_ext[i] = win[i];
    end
    win_ext[count] = s_tdata;
  end

  // Marker compares over the full window.
  always_comb begin
    is_head = 1'b1;
    is_tail = 1'b1;
    for (int i = 0; i < WinLen; i++) begin
      if (win_ext[i] != HeadMark[i]) is_head = 1'b0;
      if (win_ext[i] != TailMark[i]) is_tail = 1'b0;
    end
  end

  assign oldest = win_ext[0];

  // Per-transaction state update and queue command.
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      win_next[i] = win[i];
    end
    count_next   = count;
    in_wrap_next = in_wrap;
    skip_next    = skip;
    fd_next      = fd;
    has_next     = has;
    q_push       = 1'b0;
    q_cmd        = '0;
    q_cmd.idx    = fd;

    if (accept) begin
      if (s_tlast) begin
        // Line end: hand the pending state to the back and start a new line.
        q_push          = 1'b1;
        q_cmd.flush     = 1'b1;
        q_cmd.kind      = KIND_DONE;
        for (int i = 0; i < FlushLen; i++) begin
          q_cmd.win[i] = win[i];
        end
        q_cmd.count     = count;
        q_cmd.in_wrap   = in_wrap;
        q_cmd.has_bytes = has;
        count_next      = '0;
        in_wrap_next    = 1'b0;
        skip_next       = 1'b0;
        fd_next         = '0;
        has_next        = 1'b0;
      end else if (fd >= max_fields) begin
        // Field limit reached; the rest of the line is ignored.
      end else if (skip) begin
        skip_next = 1'b0;
      end else if (count == 3'(WinLen - 1)) begin
        if (is_head) begin
          q_push       = 1'b1;
          q_cmd.kind   = KIND_DISCARD;
          in_wrap_next = 1'b1;
          has_next     = 1'b0;
          count_next   = '0;
        end else if (in_wrap && is_tail) begin
          q_push       = 1'b1;
          q_cmd.kind   = KIND_CLOSE;
          in_wrap_next = 1'b0;
          fd_next      = fd + 8'd1;
          has_next     = 1'b0;
          count_next   = '0;
          skip_next    = 1'b1;
        end else begin
          // No marker: release the oldest byte and slide the window.
          for (int i = 0; i < WinLen - 1; i++) begin
            win_next[i] = win_ext[i + 1];
          end
          win_next[WinLen - 1] = '0;
          count_next = 3'(WinLen - 1);
          q_push     = 1'b1;
          if (oldest == CommaChar && !in_wrap) begin
            q_cmd.kind = KIND_CLOSE;
            fd_next    = fd + 8'd1;
            has_next   = 1'b0;
          end else begin
            q_cmd.kind = KIND_CONTENT;
            q_cmd.data = oldest;
            has_next   = 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < WinLen; i++) begin
          win_next[i] = win_ext[i];
        end
        count_next = 3'(count + 3'd1);
      end
    end
  end

  // Window bytes beyond the count are never read, so they need no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < WinLen; i++) begin
      win[i] <= win_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      in_wrap <= 1'b0;
      skip    <= 1'b0;
      fd      <= '0;
      has     <= 1'b0;
    end else begin
      count   <= count_next;
      in_wrap <= in_wrap_next;
      skip    <= skip_next;
      fd      <= fd_next;
      has     <= has_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/csvs_back.sv =====
// Back of the splitter: drains the command queue into the output register and,
// while it is free, steps line-end flush jobs one result per cycle. Uses csvs_pkg.
`default_nettype none

module csvs_back
  import csvs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   max_fields,
  input  wire logic         q_empty,
  input  csvs_cmd_t         q_cmd,
  output logic              q_pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [15:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  typedef enum logic [1:0] {
    ST_PASS  = 2'b01,
    ST_FLUSH = 2'b10
  } back_state_t;

  back_state_t st, st_next;

  // Flush job registers.
  logic [7:0] sw      [FlushLen];
  logic [7:0] sw_next [FlushLen];
  logic [2:0] scount, scount_next;
  logic [7:0] sfd, sfd_next;
  logic       shas, shas_next;
  logic       sinside, sinside_next;

  // Output register.
  logic       out_valid, out_valid_next;
  kind_t      out_kind, out_kind_next;
  logic [7:0] out_byte, out_byte_next;
  logic [7:0] out_idx, out_idx_next;
  logic       out_last, out_last_next;
  logic       out_free;
  logic       load;

  assign out_free = !out_valid || m_tready;

  always_comb begin
    st_next      = st;
    for (int i = 0; i < FlushLen; i++) begin
      sw_next[i] = sw[i];
    end
    scount_next   = scount;
    sfd_next      = sfd;
    shas_next     = shas;
    sinside_next  = sinside;
    q_pop         = 1'b0;
    load          = 1'b0;
    out_kind_next = out_kind;
    out_byte_next = out_byte;
    out_idx_next  = out_idx;
    out_last_next = out_last;

    case (st)
      ST_PASS: begin
        if (out_free && !q_empty) begin
          q_pop = 1'b1;
          if (q_cmd.flush) begin
            for (int i = 0; i < FlushLen; i++) begin
              sw_next[i] = q_cmd.win[i];
            end
            scount_next  = q_cmd.count;
            sfd_next     = q_cmd.idx;
            shas_next    = q_cmd.has_bytes;
            sinside_next = q_cmd.in_wrap;
            st_next      = ST_FLUSH;
          end else begin
            load          = 1'b1;
            out_kind_next = q_cmd.kind;
            out_byte_next = q_cmd.data;
            out_idx_next  = q_cmd.idx;
            out_last_next = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          load          = 1'b1;
          out_byte_next = '0;
          out_idx_next  = sfd;
          out_last_next = 1'b0;
          if (scount != '0 && sfd < max_fields) begin
            // Release the oldest pending window byte.
            for (int i = 0; i < FlushLen - 1; i++) begin
              sw_next[i] = sw[i + 1];
            end
            sw_next[FlushLen - 1] = '0;
            scount_next = scount - 3'd1;
            if (sw[0] == CommaChar && !sinside) begin
              out_kind_next = KIND_CLOSE;
              sfd_next      = sfd + 8'd1;
              shas_next     = 1'b0;
            end else begin
              out_kind_next = KIND_CONTENT;
              out_byte_next = sw[0];
              shas_next     = 1'b1;
            end
          end else if (sfd < max_fields && !sinside && shas) begin
            // Close the non-empty open field.
            out_kind_next = KIND_CLOSE;
            sfd_next      = sfd + 8'd1;
            shas_next     = 1'b0;
          end else begin
            out_kind_next = KIND_DONE;
            out_last_next = 1'b1;
            st_next       = ST_PASS;
          end
        end
      end
      default: begin
        st_next = ST_PASS;
      end
    endcase

    out_valid_next = load ? 1'b1 : (out_valid && !m_tready);
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    for (int i = 0; i < FlushLen; i++) begin
      sw[i] <= sw_next[i];
    end
    scount   <= scount_next;
    sfd      <= sfd_next;
    shas     <= shas_next;
    sinside  <= sinside_next;
    out_kind <= out_kind_next;
    out_byte <= out_byte_next;
    out_idx  <= out_idx_next;
    out_last <= out_last_next;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_PASS;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = out_kind;
  assign m_tdata  = {out_idx, out_byte};

endmodule

`default_nettype wire

// ===== design/wrapped_csv_field_splitter_core.sv =====
// Wrapped CSV field splitter, top level.
// Input stream (s_*): one character per transaction in s_tdata; s_tlast marks
// the line terminator transaction, whose data is ignored.
// Output stream (m_*): the result kind in m_tuser, {field_index, out_byte}
// in m_tdata; m_tlast is set on the last result caused by an input transaction.
// Configuration: cfg_we writes cfg_wdata into max_fields (reset value 30);
// write it only while the block is idle.
// Throughput: one character per cycle while the command queue is not full.
// Up to six of the latest characters are held in the marker window; a result
// caused by a character goes through the command queue to the output register.
// A line terminator is expanded by the back end at one result per cycle while
// the output register is free: up to six window bytes, an optional close and
// the line-done result, once its flush job has been taken from the queue.
// Characters behind a terminator wait in the four-entry command queue;
// s_tready drops only when that queue is full.
// Reset (rst, synchronous) empties the queue and output register and clears
// the line state. A stalled receiver holds the output register, the queue
// fills, and then the input side stalls.
`default_nettype none

`include "wrapped_csv_field_splitter_core_assert.svh"

module wrapped_csv_field_splitter_core
  import csvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream; s_tdata: in_byte [7:0]. s_tlast: end_of_line.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  // Output stream; m_tdata: out_byte [7:0], field_index [15:8].
  // m_tuser: kind [1:0]. m_tlast: last_of_run.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast,
  // Configuration write of max_fields.
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0] max_fields;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  csvs_cmd_t  q_in;
  csvs_cmd_t  q_out;

  // Field limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_fields <= MaxFieldsReset;
    end else if (cfg_we) begin
      max_fields <= cfg_wdata;
    end
  end

  csvs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .max_fields (max_fields),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in)
  );

  csvs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  csvs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .max_fields (max_fields),
    .q_empty    (q_empty),
    .q_cmd      (q_out),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // The front never writes into a full queue.
  `CSVS_ASSERT_NOW(a_no_push_full, clk, rst, q_push, !q_full)
  // A line-done result always ends its run.
  `CSVS_ASSERT_NOW(a_done_is_last, clk, rst, m_tvalid && m_tuser == KIND_DONE, m_tlast)
  // Only content results carry a character.
  `CSVS_ASSERT_NOW(a_mark_no_byte, clk, rst, m_tvalid && m_tuser != KIND_CONTENT, m_tdata[7:0] == 8'd0)
  // No pop can follow a cycle in which the queue was empty and received no push.
  `CSVS_ASSERT_NEXT(a_pop_needs_data, clk, rst, q_empty && !q_push, !q_pop)

endmodule

`default_nettype wire
